[hw/rtl/pfd_pkg.sv]
// shared constants and types for the page frame directory
`timescale 1ns / 1ps
package pfd_pkg;
    localparam int FRAMES = 16;
    localparam int FIDX_W = 4;
    localparam int PAGE_W = 32;
    localparam int PIN_W = 16;
    localparam int STAMP_W = 64;

    localparam logic [2:0] ACT_FETCH = 3'd0;
    localparam logic [2:0] ACT_NEW = 3'd1;
    localparam logic [2:0] ACT_UNPIN = 3'd2;
    localparam logic [2:0] ACT_DIRTY = 3'd3;
    localparam logic [2:0] ACT_FLUSH = 3'd4;
    localparam logic [2:0] ACT_FLALL = 3'd5;

    localparam logic [2:0] ST_DONE = 3'd0;
    localparam logic [2:0] ST_HIT = 3'd1;
    localparam logic [2:0] ST_MISS = 3'd2;
    localparam logic [2:0] ST_ALLPIN = 3'd3;
    localparam logic [2:0] ST_UNDER = 3'd4;
    localparam logic [2:0] ST_OVER = 3'd5;

    // per-frame contents
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [PIN_W-1:0] pins;
        logic dirty;
        logic occ;
        logic [STAMP_W-1:0] stamp;
    } frame_t;

    // scan token handed from cell to cell
    typedef struct packed {
        logic found;               // first matching frame seen
        logic [FIDX_W-1:0] match;
        logic free;                // first free frame seen
        logic [FIDX_W-1:0] free_idx;
        logic cand;                // unpinned candidate seen
        logic [FIDX_W-1:0] cand_idx;
        logic [STAMP_W-1:0] cand_stamp;
    } scan_t;

    // update command broadcast to all cells
    typedef struct packed {
        logic en;
        logic [FIDX_W-1:0] idx;
        frame_t val;
    } upd_t;
endpackage

[hw/rtl/page_frame_directory_lru_top.sv]
// top level: frame cell chain plus request sequencer
// the scan token moves one cell per cycle through the cell chain before the result is computed
// a new request is accepted only when idle; flush all walks every frame with one word per dirty frame
// the result register holds a word until taken while the next request waits
// reset: synchronous active-low aresetn clears all frames, clock and counters
`timescale 1ns / 1ps
module page_frame_directory_lru_top import pfd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic [2:0] s_action,
    input  logic [31:0] s_page_id,
    input  logic [7:0] s_page_type,
    input  logic [3:0] s_frame_index,
    output logic m_valid,
    input  logic m_ready,
    output logic [2:0] m_status,
    output logic [3:0] m_frame,
    output logic m_load_request,
    output logic m_init_request,
    output logic [7:0] m_init_type,
    output logic m_writeback_valid,
    output logic [31:0] m_writeback_page,
    output logic [3:0] m_writeback_frame,
    output logic m_store_flush,
    output logic m_last,
    output logic [31:0] m_hit_count,
    output logic [31:0] m_miss_count
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_EXEC = 5'b00100,
        S_FLALL = 5'b01000,
        S_OUT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] act_reg;
    logic [PAGE_W-1:0] pid_reg;
    logic [7:0] ptype_reg;
    logic [FIDX_W-1:0] fi_reg;
    logic [FIDX_W:0] cnt_reg;
    logic [STAMP_W-1:0] clk_reg;
    logic [31:0] hit_reg, miss_reg;
    logic flall_done;

    scan_t chain [FRAMES+1];
    frame_t frms [FRAMES];
    upd_t upd;

    // scan token enters empty
    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < FRAMES; g++) begin : g_cell
            pfd_cell u_cell (
                .aclk(aclk), .aresetn(aresetn),
                .my_idx(FIDX_W'(g)), .key(pid_reg),
                .scan_in(chain[g]), .scan_out(chain[g+1]),
                .upd(upd), .frm(frms[g])
            );
        end
    endgenerate

    scan_t sc;
    assign sc = chain[FRAMES];
    logic [STAMP_W-1:0] clk_inc;
    assign clk_inc = (clk_reg == '1) ? clk_reg : clk_reg + 1'b1;

    // output word register
    logic [2:0] o_status;
    logic [3:0] o_frame, o_wbf;
    logic o_load, o_init, o_wbv, o_sf, o_last;
    logic [7:0] o_itype;
    logic [31:0] o_wbp;
    logic [31:0] hit_next, miss_next;
    logic [STAMP_W-1:0] clk_next;
    logic load_out;
    frame_t cf, sel;
    logic [FIDX_W-1:0] vi;

    assign s_ready = (state_reg == S_IDLE);
    assign cf = frms[cnt_reg[FIDX_W-1:0]];
    assign flall_done = cnt_reg[FIDX_W];

    // next-state logic; the execute and flush-all steps compute the result word and frame update
    always_comb begin
        state_next = state_reg;
        upd = '0;
        load_out = 1'b0;
        o_status = ST_DONE; o_frame = '0; o_load = 1'b0; o_init = 1'b0;
        o_itype = '0; o_wbv = 1'b0; o_wbp = '0; o_wbf = '0; o_sf = 1'b0;
        o_last = 1'b1;
        hit_next = hit_reg; miss_next = miss_reg; clk_next = clk_reg;
        sel = frms[fi_reg];
        vi = sc.free ? sc.free_idx : sc.cand_idx;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = (s_action == ACT_FLALL) ? S_FLALL : S_SCAN;
            end
            S_SCAN: begin
                if (cnt_reg == (FIDX_W+1)'(FRAMES)) state_next = S_EXEC;
            end
            S_EXEC: begin
                load_out = 1'b1;
                state_next = S_OUT;
                case (act_reg)
                    ACT_FETCH, ACT_NEW: begin
                        if (act_reg == ACT_FETCH && sc.found) begin
                            sel = frms[sc.match];
                            if (hit_reg != '1) hit_next = hit_reg + 1'b1;
                            upd.en = 1'b1; upd.idx = sc.match; upd.val = sel;
                            if (sel.pins == '1) o_status = ST_OVER;
                            else begin
                                o_status = ST_HIT;
                                upd.val.pins = sel.pins + 1'b1;
                            end
                            clk_next = clk_inc;
                            upd.val.stamp = clk_inc;
                            o_frame = sc.match;
                        end else begin
                            if (act_reg == ACT_FETCH && miss_reg != '1)
                                miss_next = miss_reg + 1'b1;
                            if (!sc.free && !sc.cand) o_status = ST_ALLPIN;
                            else begin
                                sel = frms[vi];
                                if (!sc.free && sel.dirty) begin
                                    o_wbv = 1'b1; o_wbp = sel.page; o_wbf = vi;
                                end
                                clk_next = clk_inc;
                                upd.en = 1'b1; upd.idx = vi;
                                upd.val.page = pid_reg; upd.val.pins = PIN_W'(1);
                                upd.val.occ = 1'b1; upd.val.stamp = clk_inc;
                                upd.val.dirty = (act_reg == ACT_NEW);
                                o_frame = vi;
                                if (act_reg == ACT_FETCH) begin
                                    o_status = ST_MISS; o_load = 1'b1;
                                end else begin
                                    o_init = 1'b1; o_itype = ptype_reg;
                                end
                            end
                        end
                    end
                    ACT_UNPIN: begin
                        o_frame = fi_reg;
                        if (sel.pins == '0) o_status = ST_UNDER;
                        else begin
                            clk_next = clk_inc;
                            upd.en = 1'b1; upd.idx = fi_reg; upd.val = sel;
                            upd.val.pins = sel.pins - 1'b1; upd.val.stamp = clk_inc;
                        end
                    end
                    ACT_DIRTY: begin
                        o_frame = fi_reg;
                        clk_next = clk_inc;
                        upd.en = 1'b1; upd.idx = fi_reg; upd.val = sel;
                        upd.val.dirty = 1'b1; upd.val.stamp = clk_inc;
                    end
                    ACT_FLUSH: begin
                        if (sc.found) begin
                            sel = frms[sc.match];
                            o_frame = sc.match;
                            if (sel.dirty) begin
                                o_wbv = 1'b1; o_wbp = sel.page; o_wbf = sc.match;
                                upd.en = 1'b1; upd.idx = sc.match; upd.val = sel;
                                upd.val.dirty = 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_FLALL: begin
                // walk frames one per cycle, pausing on each dirty one until its word is taken
                if (flall_done) begin
                    load_out = 1'b1; o_sf = 1'b1; state_next = S_OUT;
                end else if (cf.occ && cf.dirty) begin
                    load_out = 1'b1; o_last = 1'b0;
                    o_wbv = 1'b1; o_wbp = cf.page; o_wbf = cnt_reg[FIDX_W-1:0];
                    upd.en = 1'b1; upd.idx = cnt_reg[FIDX_W-1:0]; upd.val = cf;
                    upd.val.dirty = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) state_next = m_last ? S_IDLE : S_FLALL;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            clk_reg <= '0; hit_reg <= '0; miss_reg <= '0;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            clk_reg <= clk_next; hit_reg <= hit_next; miss_reg <= miss_next;
            if (state_reg == S_IDLE) cnt_reg <= '0;
            else if (state_reg == S_SCAN) cnt_reg <= cnt_reg + 1'b1;
            else if (state_reg == S_FLALL && !flall_done && !load_out)
                cnt_reg <= cnt_reg + 1'b1;
            else if (state_reg == S_OUT && m_ready && !m_last)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // request capture and result word
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg <= s_action; pid_reg <= s_page_id;
            ptype_reg <= s_page_type; fi_reg <= s_frame_index;
        end
        if (load_out) begin
            m_status <= o_status; m_frame <= o_frame; m_load_request <= o_load;
            m_init_request <= o_init; m_init_type <= o_itype;
            m_writeback_valid <= o_wbv; m_writeback_page <= o_wbp;
            m_writeback_frame <= o_wbf; m_store_flush <= o_sf; m_last <= o_last;
            m_hit_count <= hit_next; m_miss_count <= miss_next;
        end
    end

    assign m_valid = (state_reg == S_OUT);

    // never accept while a word is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("accept during output");
    // store flush only ever on a final word
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_store_flush) |-> m_last) else $error("flush not last");
    // hit counter never decreases
    a_hit_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_reg >= $past(hit_reg) || $past(!aresetn)) else $error("hit count fell");
endmodule

[hw/rtl/pfd_cell.sv]
// one frame slot: holds the frame, folds itself into the scan token
`timescale 1ns / 1ps
module pfd_cell import pfd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic [FIDX_W-1:0] my_idx,
    input  logic [PAGE_W-1:0] key,
    input  scan_t scan_in,
    output scan_t scan_out,
    input  upd_t upd,
    output frame_t frm
);
    frame_t frm_reg;
    scan_t scan_reg, scan_next;

    assign frm = frm_reg;
    assign scan_out = scan_reg;

    // fold this frame into the token
    always_comb begin
        scan_next = scan_in;
        if (!scan_in.found && frm_reg.occ && frm_reg.page == key) begin
            scan_next.found = 1'b1;
            scan_next.match = my_idx;
        end
        if (!scan_in.free && !frm_reg.occ) begin
            scan_next.free = 1'b1;
            scan_next.free_idx = my_idx;
        end
        if (frm_reg.pins == '0 &&
            (!scan_in.cand || frm_reg.stamp < scan_in.cand_stamp)) begin
            scan_next.cand = 1'b1;
            scan_next.cand_idx = my_idx;
            scan_next.cand_stamp = frm_reg.stamp;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        if (!aresetn) begin
            frm_reg <= '0;
        end else if (upd.en && upd.idx == my_idx) begin
            frm_reg <= upd.val;
        end
    end
endmodule
